@@ src/psq_pkg.sv @@
// shared types, constants and codes for the positional sequence table
package psq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int GROUP      = 8;
    localparam int GROUP_W    = $clog2(GROUP);
    localparam int NGROUP     = (CAPACITY + GROUP - 1) / GROUP;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_AT     = 3'd0,
        OP_INSERT_SORTED = 3'd1,
        OP_ERASE_AT      = 3'd2,
        OP_REMOVE_ALL    = 3'd3,
        OP_GET           = 3'd4,
        OP_SET           = 3'd5,
        OP_FIND          = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  result_index;
        logic [WORD_W-1:0] read_value;
        logic [POS_W-1:0]  removed_count;
        logic [POS_W-1:0]  current_count;
    } rsp_t;

    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      at;
        logic [DATA_WIDTH-1:0] word;
        logic [POS_W-1:0]      pos;
        logic [CNT_W-1:0]      count;
    } cell_bus_t;

    typedef struct packed {
        logic eq;
        logic ge;
        logic sel;
    } cell_flags_t;

    typedef struct packed {
        logic                  eq_found;
        logic [IDX_W-1:0]      eq_index;
        logic                  ge_found;
        logic [IDX_W-1:0]      ge_index;
        logic [DATA_WIDTH-1:0] read_word;
    } reduce_t;

endpackage

@@ src/psq_cell.sv @@
// one storage cell of the table: holds a word, shifts with its neighbors, flags matches
module psq_cell (
    input  logic                           clk,
    input  logic [psq_pkg::IDX_W-1:0]      idx,
    input  psq_pkg::cell_bus_t             bus,
    input  logic [psq_pkg::DATA_WIDTH-1:0] left,
    input  logic [psq_pkg::DATA_WIDTH-1:0] right,
    output logic [psq_pkg::DATA_WIDTH-1:0] data,
    output psq_pkg::cell_flags_t           flags
);
    import psq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  in_use;

    assign in_use    = CNT_W'(idx) < bus.count;
    assign flags.eq  = in_use && (data_reg == bus.word);
    assign flags.ge  = in_use && !(data_reg < bus.word);
    assign flags.sel = POS_W'(idx) == bus.pos;
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (bus.op)
            CELL_INSERT:
            begin
                if (idx == bus.at)
                begin
                    data_next = bus.word;
                end
                else if (idx > bus.at)
                begin
                    data_next = left;
                end
            end
            CELL_ERASE:
            begin
                if (idx >= bus.at)
                begin
                    data_next = right;
                end
            end
            CELL_WRITE:
            begin
                if (idx == bus.at)
                begin
                    data_next = bus.word;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ src/psq_reduce.sv @@
// two-level registered first-match search and read select over the cell row
module psq_reduce (
    input  logic                           clk,
    input  psq_pkg::cell_flags_t           flags [psq_pkg::CAPACITY],
    input  logic [psq_pkg::DATA_WIDTH-1:0] data  [psq_pkg::CAPACITY],
    output psq_pkg::reduce_t               red
);
    import psq_pkg::*;

    logic                  eq_any_reg [NGROUP];
    logic [GROUP_W-1:0]    eq_sub_reg [NGROUP];
    logic                  ge_any_reg [NGROUP];
    logic [GROUP_W-1:0]    ge_sub_reg [NGROUP];
    logic [DATA_WIDTH-1:0] or_reg     [NGROUP];

    logic                  eq_any_next [NGROUP];
    logic [GROUP_W-1:0]    eq_sub_next [NGROUP];
    logic                  ge_any_next [NGROUP];
    logic [GROUP_W-1:0]    ge_sub_next [NGROUP];
    logic [DATA_WIDTH-1:0] or_next     [NGROUP];

    // first level: inside each group of cells
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            eq_any_next[g] = 1'b0;
            eq_sub_next[g] = '0;
            ge_any_next[g] = 1'b0;
            ge_sub_next[g] = '0;
            or_next[g]     = '0;
            for (int s = GROUP - 1; s >= 0; s--)
            begin
                if (g * GROUP + s < CAPACITY)
                begin
                    if (flags[g * GROUP + s].eq)
                    begin
                        eq_any_next[g] = 1'b1;
                        eq_sub_next[g] = GROUP_W'(s);
                    end
                    if (flags[g * GROUP + s].ge)
                    begin
                        ge_any_next[g] = 1'b1;
                        ge_sub_next[g] = GROUP_W'(s);
                    end
                    if (flags[g * GROUP + s].sel)
                    begin
                        or_next[g] = or_next[g] | data[g * GROUP + s];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            eq_any_reg[g] <= eq_any_next[g];
            eq_sub_reg[g] <= eq_sub_next[g];
            ge_any_reg[g] <= ge_any_next[g];
            ge_sub_reg[g] <= ge_sub_next[g];
            or_reg[g]     <= or_next[g];
        end
    end

    // second level: across groups
    always_comb
    begin
        red = '0;
        for (int g = NGROUP - 1; g >= 0; g--)
        begin
            if (eq_any_reg[g])
            begin
                red.eq_found = 1'b1;
                red.eq_index = IDX_W'(g * GROUP + int'(eq_sub_reg[g]));
            end
            if (ge_any_reg[g])
            begin
                red.ge_found = 1'b1;
                red.ge_index = IDX_W'(g * GROUP + int'(ge_sub_reg[g]));
            end
            red.read_word = red.read_word | or_reg[g];
        end
    end

endmodule

@@ src/positional_sequence_table.sv @@
// top level: bounded ordered list held in a chain of cells, with request sequencer
//
//  channel   signals             handshake
//  request   req (req_t)         taken when start && !busy
//  result    rsp (rsp_t)         one-cycle beat marked by done, no back-pressure
//
//  a request passes through the compare and select states to its done beat; remove_all
//  repeats the compare and select pass per entry removed, one entry closed up per pass through the row
//  busy is low again in the cycle of the done beat, so a new request can be taken in that cycle
//  reset clears the count, state and result registers; stored words stay undefined until written
//  results cannot be stalled
module positional_sequence_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  psq_pkg::req_t req,
    output logic          done,
    output psq_pkg::rsp_t rsp
);
    import psq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  removed_reg, removed_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    cell_bus_t             bus;
    cell_flags_t           flags [CAPACITY];
    logic [DATA_WIDTH-1:0] data  [CAPACITY];
    reduce_t               red;

    logic [CNT_W-1:0]      pos_c;
    logic [IDX_W-1:0]      sorted_at;

    assign pos_c     = CNT_W'(req_reg.position);
    assign sorted_at = red.ge_found ? red.ge_index : count_reg[IDX_W-1:0];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            psq_cell u_cell (
                .clk   (clk),
                .idx   (IDX_W'(i)),
                .bus   (bus),
                .left  (data[(i == 0) ? 0 : i - 1]),
                .right (data[(i == CAPACITY - 1) ? i : i + 1]),
                .data  (data[i]),
                .flags (flags[i])
            );
        end
    endgenerate

    psq_reduce u_reduce (
        .clk   (clk),
        .flags (flags),
        .data  (data),
        .red   (red)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;

        bus.op    = CELL_HOLD;
        bus.at    = req_reg.position[IDX_W-1:0];
        bus.word  = req_reg.item_value[DATA_WIDTH-1:0];
        bus.pos   = req_reg.position;
        bus.count = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next   = S_CMP;
                    removed_next = '0;
                end
            end
            S_CMP:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                rsp_next   = '0;
                case (req_reg.operation)
                    OP_INSERT_AT:
                    begin
                        if (pos_c > count_reg)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            bus.op     = CELL_INSERT;
                            count_next = count_reg + CNT_W'(1);
                            rsp_next.result_index = req_reg.position;
                        end
                    end
                    OP_INSERT_SORTED:
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            bus.op     = CELL_INSERT;
                            bus.at     = sorted_at;
                            count_next = count_reg + CNT_W'(1);
                            rsp_next.result_index = POS_W'(sorted_at);
                        end
                    end
                    OP_ERASE_AT:
                    begin
                        if (pos_c >= count_reg)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            bus.op     = CELL_ERASE;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    OP_REMOVE_ALL:
                    begin
                        if (red.eq_found)
                        begin
                            // close up the first match and search again
                            bus.op       = CELL_ERASE;
                            bus.at       = red.eq_index;
                            count_next   = count_reg - CNT_W'(1);
                            removed_next = removed_reg + POS_W'(1);
                            state_next   = S_CMP;
                            done_next    = 1'b0;
                            rsp_next     = rsp_reg;
                        end
                        else
                        begin
                            rsp_next.removed_count = removed_reg;
                        end
                    end
                    OP_GET:
                    begin
                        if (pos_c >= count_reg)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            rsp_next.read_value = WORD_W'(red.read_word);
                        end
                    end
                    OP_SET:
                    begin
                        if (pos_c >= count_reg)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            bus.op = CELL_WRITE;
                        end
                    end
                    OP_FIND:
                    begin
                        if (red.eq_found)
                        begin
                            rsp_next.result_index = POS_W'(red.eq_index);
                        end
                        else
                        begin
                            rsp_next.status = ST_MISSING;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_OK;
                    end
                endcase
                rsp_next.current_count = POS_W'(count_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            removed_reg <= '0;
            done_reg    <= 1'b0;
            rsp_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            removed_reg <= removed_next;
            done_reg    <= done_next;
            rsp_reg     <= rsp_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= req;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ sim/positional_sequence_table_test.sv @@
// testbench for positional_sequence_table: directed table, then random list traffic checked against a behavioral list
`timescale 1ns / 100ps

module positional_sequence_table_test;
    import psq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int ITEMS = 1100;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 140;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    logic [DATA_WIDTH-1:0] list_words [CAPACITY];
    int unsigned list_len;
    bit filling;
    int unsigned full_picks;
    rsp_t rsp_due [$];
    row_t script [$];
    int errs;
    int quiet;
    int idle_pct;

    positional_sequence_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic req_t mk_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                    logic [WORD_W-1:0] val);
        req_t r;
        r.operation  = op;
        r.position   = pos;
        r.item_value = val;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(status_t st, logic [POS_W-1:0] idx,
                                    logic [WORD_W-1:0] rd, logic [POS_W-1:0] rm,
                                    logic [POS_W-1:0] cnt);
        rsp_t o;
        o.status        = st;
        o.result_index  = idx;
        o.read_value    = rd;
        o.removed_count = rm;
        o.current_count = cnt;
        return o;
    endfunction

    // applies one request to the list copy and returns its result beat
    function automatic rsp_t list_apply(req_t r);
        rsp_t o;
        int unsigned p;
        int unsigned k;
        int unsigned w;
        logic [DATA_WIDTH-1:0] v;
        o = '0;
        p = r.position;
        v = r.item_value;
        case (r.operation)
            OP_INSERT_AT, OP_INSERT_SORTED:
            begin
                if (r.operation == OP_INSERT_SORTED)
                begin
                    p = 0;
                    while (p < list_len && list_words[p] < v)
                        p++;
                end
                if (p > list_len)
                    o.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    for (k = list_len; k > p; k--)
                        list_words[k] = list_words[k-1];
                    list_words[p] = v;
                    list_len++;
                    o.result_index = POS_W'(p);
                end
            end
            OP_ERASE_AT:
            begin
                if (p >= list_len)
                    o.status = ST_RANGE;
                else
                begin
                    for (k = p; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
            OP_REMOVE_ALL:
            begin
                w = 0;
                for (k = 0; k < list_len; k++)
                begin
                    if (list_words[k] != v)
                    begin
                        list_words[w] = list_words[k];
                        w++;
                    end
                end
                o.removed_count = POS_W'(list_len - w);
                list_len = w;
            end
            OP_GET:
            begin
                if (p >= list_len)
                    o.status = ST_RANGE;
                else
                    o.read_value = list_words[p];
            end
            OP_SET:
            begin
                if (p >= list_len)
                    o.status = ST_RANGE;
                else
                    list_words[p] = v;
            end
            OP_FIND:
            begin
                o.status = ST_MISSING;
                for (k = 0; k < list_len; k++)
                begin
                    if (list_words[k] == v)
                    begin
                        o.status = ST_OK;
                        o.result_index = POS_W'(k);
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        o.current_count = POS_W'(list_len);
        return o;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35 && list_len > 0)
            return list_words[$urandom_range(list_len - 1)];
        if (roll < 65)
        begin
            case ($urandom_range(5))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                3: return 32'h7FFF_FFFF;
                4: return 32'h0000_0001;
                default: return 32'hA5A5_5A5A;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(int unsigned span);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70 && span > 0)
            return POS_W'($urandom_range(span - 1));
        if (roll < 80)
            return POS_W'(span);
        if (roll < 85)
            return POS_W'(CAPACITY);
        return POS_W'($urandom_range(127));
    endfunction

    // grows the list to full, then drains it, with random content throughout
    function automatic req_t pick_request();
        req_t r;
        int unsigned roll;
        int unsigned span;
        logic [OP_W-1:0] op;
        if (filling && list_len == CAPACITY)
        begin
            full_picks++;
            if (full_picks > 4)
                filling = 1'b0;
        end
        else if (!filling && list_len == 0)
        begin
            filling = 1'b1;
            full_picks = 0;
        end
        roll = $urandom_range(99);
        if (filling)
            op = roll < 30 ? OP_INSERT_AT : roll < 60 ? OP_INSERT_SORTED :
                 roll < 65 ? OP_ERASE_AT : roll < 67 ? OP_REMOVE_ALL :
                 roll < 77 ? OP_GET : roll < 85 ? OP_SET :
                 roll < 98 ? OP_FIND : OP_UNUSED;
        else
            op = roll < 6 ? OP_INSERT_AT : roll < 12 ? OP_INSERT_SORTED :
                 roll < 47 ? OP_ERASE_AT : roll < 57 ? OP_REMOVE_ALL :
                 roll < 70 ? OP_GET : roll < 80 ? OP_SET :
                 roll < 98 ? OP_FIND : OP_UNUSED;
        span = (op == OP_INSERT_AT) ? list_len + 1 : list_len;
        r = mk_req(op, pick_pos(span), pick_word());
        return r;
    endfunction

    task automatic report_bad(string what, rsp_t want, rsp_t got);
        if (errs < 10)
            $display("%0t %s: want st=%0d idx=%0d rd=%h rm=%0d cnt=%0d, got st=%0d idx=%0d rd=%h rm=%0d cnt=%0d",
                     $time, what, want.status, want.result_index, want.read_value,
                     want.removed_count, want.current_count, got.status, got.result_index,
                     got.read_value, got.removed_count, got.current_count);
        errs++;
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(req_t r, bit typed, rsp_t typed_want);
        rsp_t want;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        want = list_apply(r);
        if (typed)
            want = typed_want;
        rsp_due.push_back(want);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rsp_due.size() == 0)
                report_bad("unexpected beat", '0, rsp);
            else
            begin
                rsp_t want;
                want = rsp_due.pop_front();
                if (rsp.status !== want.status || rsp.result_index !== want.result_index ||
                    rsp.read_value !== want.read_value ||
                    rsp.removed_count !== want.removed_count ||
                    rsp.current_count !== want.current_count)
                    report_bad("mismatch", want, rsp);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("positional_sequence_table_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int made;
        req_t r;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        errs = 0;
        quiet = 0;
        list_len = 0;
        filling = 1'b1;
        full_picks = 0;
        idle_pct = 25;

        // typed rows follow the list at a glance, the rest use the list copy
        script.push_back('{mk_req(OP_GET, 0, 0), 1, mk_rsp(ST_RANGE, 0, 0, 0, 0)});
        script.push_back('{mk_req(OP_ERASE_AT, 0, 0), 1, mk_rsp(ST_RANGE, 0, 0, 0, 0)});
        script.push_back('{mk_req(OP_SET, 0, 32'hFFFF_FFFF), 1, mk_rsp(ST_RANGE, 0, 0, 0, 0)});
        script.push_back('{mk_req(OP_FIND, 0, 0), 1, mk_rsp(ST_MISSING, 0, 0, 0, 0)});
        script.push_back('{mk_req(OP_REMOVE_ALL, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0)});
        script.push_back('{mk_req(OP_INSERT_AT, 1, 5), 1, mk_rsp(ST_RANGE, 0, 0, 0, 0)});
        script.push_back('{mk_req(OP_INSERT_AT, 127, 32'hFFFF_FFFF), 1,
                           mk_rsp(ST_RANGE, 0, 0, 0, 0)});
        script.push_back('{mk_req(OP_UNUSED, 127, 32'hFFFF_FFFF), 1, mk_rsp(ST_OK, 0, 0, 0, 0)});
        script.push_back('{mk_req(OP_INSERT_AT, 0, 32'hFFFF_FFFF), 1, mk_rsp(ST_OK, 0, 0, 0, 1)});
        script.push_back('{mk_req(OP_INSERT_SORTED, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 2)});
        script.push_back('{mk_req(OP_INSERT_SORTED, 0, 32'h8000_0000), 1,
                           mk_rsp(ST_OK, 1, 0, 0, 3)});
        script.push_back('{mk_req(OP_INSERT_AT, 3, 0), 1, mk_rsp(ST_OK, 3, 0, 0, 4)});
        script.push_back('{mk_req(OP_GET, 3, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 4)});
        script.push_back('{mk_req(OP_GET, 2, 0), 1, mk_rsp(ST_OK, 0, 32'hFFFF_FFFF, 0, 4)});
        script.push_back('{mk_req(OP_GET, 4, 0), 1, mk_rsp(ST_RANGE, 0, 0, 0, 4)});
        script.push_back('{mk_req(OP_FIND, 0, 0), 0, '0});
        script.push_back('{mk_req(OP_INSERT_SORTED, 0, 0), 0, '0});
        script.push_back('{mk_req(OP_SET, 1, 32'h55AA_55AA), 0, '0});
        script.push_back('{mk_req(OP_FIND, 0, 32'h1234_5678), 0, '0});
        script.push_back('{mk_req(OP_REMOVE_ALL, 0, 0), 0, '0});
        script.push_back('{mk_req(OP_ERASE_AT, 1, 0), 0, '0});
        script.push_back('{mk_req(OP_ERASE_AT, 64, 0), 0, '0});
        script.push_back('{mk_req(OP_UNUSED, 0, 0), 0, '0});
        script.push_back('{mk_req(OP_INSERT_SORTED, 0, 32'hFFFF_FFFF), 0, '0});
        script.push_back('{mk_req(OP_GET, 0, 0), 0, '0});

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
            send_beat(script[i].r, script[i].typed, script[i].want);

        for (ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 25 : (ph == 1) ? 53 : 0;
            made = 0;
            while (made < ITEMS / 3)
            begin
                r = pick_request();
                if (r.operation != OP_UNUSED)
                    made++;
                send_beat(r, 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errs == 0 && rsp_due.size() == 0)
            $display("positional_sequence_table_test: done, clean");
        else
            $display("positional_sequence_table_test: done, errors");
        $finish;
    end

endmodule
